FILE: rtl/core/crc_frame_checker_defines.svh
// assertion macros used by the checker file
`ifndef CRC_FRAME_CHECKER_DEFINES_SVH
`define CRC_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define CFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/crc_fc_pkg.sv
`default_nettype none

package crc_fc_pkg;

   // fixed field widths
   localparam int BYTE_W      = 8;
   localparam int DATA_W      = 8;
   localparam int NIBBLE_W    = 4;
   localparam int ERR_W       = 2;
   localparam int TOTAL_W     = 32;
   localparam int POLY_W      = 9;
   localparam int GLEN_W      = 4;
   localparam int PAD_W       = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   // shortest generator the datapath honors
   localparam int MIN_GEN_LEN = 2;

   // register values after reset
   localparam logic              WIDE_RESET = 1'b1;
   localparam logic [POLY_W-1:0] POLY_RESET = 9'd11;
   localparam logic [GLEN_W-1:0] GLEN_RESET = 4'd4;
   localparam logic [PAD_W-1:0]  PAD_RESET  = 3'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDE_MODE = 2'd0,
      CSR_GEN_POLY  = 2'd1,
      CSR_GEN_LEN   = 2'd2,
      CSR_PAD_BITS  = 2'd3
   } csr_reg_type;

endpackage

`default_nettype wire

FILE: rtl/core/crc_frame_checker.sv
// crc frame checker
//
// req_ channel: one stream byte per item (req_in_byte, msb first), taken at an
// edge with req_valid high and req_stall low. bytes gather into frames whose
// size follows from padding_bits, generator_length and wide_mode.
// rsp_ channel: one item per completed frame with the recovered data byte,
// the frame's error count and the running codeword and error totals.
// csr_ channel: register writes by index (0 wide_mode, 1 generator_poly,
// 2 generator_length, 3 padding_bits); csr_ready is always high. a write to
// any register but the polynomial drops the partly gathered frame.
// throughput: one byte per cycle while req_stall is low, set by the byte
// gather register; the remainder check is a fixed xor network between the
// frame register and the result register. once the last byte of a frame is
// taken, its result passes through the frame register, then the result register.
// while rsp_stall holds a result, bytes keep arriving until a second frame
// completes and waits in the frame register; only then req_stall rises.
// reset: registers return to their defaults, tallies and gather state clear.

`default_nettype none

module crc_frame_checker #(
   parameter int MAX_GEN_LEN = 9,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // byte input
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [crc_fc_pkg::BYTE_W-1:0]       req_in_byte,
   // frame results
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [crc_fc_pkg::DATA_W-1:0]            rsp_data_byte,
   output logic [crc_fc_pkg::ERR_W-1:0]             rsp_frame_errors,
   output logic [crc_fc_pkg::TOTAL_W-1:0]           rsp_total_codewords,
   output logic [crc_fc_pkg::TOTAL_W-1:0]           rsp_total_errors,
   // register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [crc_fc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [crc_fc_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int BYTE_W     = crc_fc_pkg::BYTE_W;
   localparam int DATA_W     = crc_fc_pkg::DATA_W;
   localparam int NIBBLE_W   = crc_fc_pkg::NIBBLE_W;
   localparam int GL_W       = $clog2(MAX_GEN_LEN + 1);
   localparam int CW_W       = DATA_W - 1 + MAX_GEN_LEN;
   localparam int LEN_W      = $clog2(CW_W + 1);
   // longest frame in bits: narrow mode, seven pad bits
   localparam int MAX_RAW    = 2 * (NIBBLE_W - 1 + MAX_GEN_LEN) + 7;
   localparam int FB_W       = $clog2(MAX_RAW + 1);
   localparam int MAX_BYTES  = MAX_RAW / BYTE_W;
   localparam int FRAME_W    = MAX_BYTES * BYTE_W;
   localparam int CNT_W      = $clog2(MAX_BYTES + 1);
   localparam int EXT_W      = FRAME_W + CW_W;
   localparam int SH_W       = $clog2(EXT_W + 1);
   localparam int POLY_EXT_W = (MAX_GEN_LEN > crc_fc_pkg::POLY_W) ?
                               MAX_GEN_LEN : crc_fc_pkg::POLY_W;
   localparam int TOT_EXT_W  = (COUNT_WIDTH > crc_fc_pkg::TOTAL_W) ?
                               COUNT_WIDTH : crc_fc_pkg::TOTAL_W;

   // configuration registers
   logic                              cfg_wide_ff;
   logic [crc_fc_pkg::POLY_W-1:0]     cfg_poly_ff;
   logic [crc_fc_pkg::GLEN_W-1:0]     cfg_glen_ff;
   logic [crc_fc_pkg::PAD_W-1:0]      cfg_pad_ff;
   logic                              csr_take;
   logic                              frame_drop;

   // byte gather
   logic [FRAME_W-1:0]                frame_ff;
   logic [CNT_W-1:0]                  count_ff;
   logic [FRAME_W-1:0]                shifted;
   logic [CNT_W-1:0]                  count_inc;
   logic [CNT_W-1:0]                  frame_bytes;
   logic [CNT_W-1:0]                  byte_gap;
   logic [FB_W-1:0]                   frame_bits;
   logic                              frame_done;
   logic                              req_take;

   // completed frame, left aligned
   logic                              hold_vld_ff;
   logic [FRAME_W-1:0]                hold_frame_ff;
   logic                              hold_move;
   logic                              out_free;

   // check datapath
   logic [GL_W-1:0]                   gen_len;
   logic [LEN_W-1:0]                  cw_len;
   logic [CW_W:0]                     len_mask_full;
   logic [CW_W-1:0]                   len_mask;
   logic [EXT_W-1:0]                  frame_ext;
   logic [SH_W-1:0]                   sh_hi;
   logic [SH_W-1:0]                   sh_lo;
   logic [EXT_W-1:0]                  cw_hi_raw;
   logic [EXT_W-1:0]                  cw_lo_raw;
   logic [CW_W-1:0]                   cw_hi;
   logic [CW_W-1:0]                   cw_lo;
   logic [CW_W-1:0]                   data_hi;
   logic [CW_W-1:0]                   data_lo;
   logic [POLY_EXT_W-1:0]             poly_ext;
   logic [MAX_GEN_LEN:0]              gen_mask;
   logic [MAX_GEN_LEN-1:0]            gen_div;
   logic                              err_hi;
   logic                              err_lo;
   logic [DATA_W-1:0]                 data_in;
   logic [crc_fc_pkg::ERR_W-1:0]      errs_in;
   logic [crc_fc_pkg::ERR_W-1:0]      ncw;

   // results and tallies
   logic                              rsp_valid_ff;
   logic [DATA_W-1:0]                 rsp_data_ff;
   logic [crc_fc_pkg::ERR_W-1:0]      rsp_errs_ff;
   logic [COUNT_WIDTH-1:0]            cw_tally_ff;
   logic [COUNT_WIDTH-1:0]            err_tally_ff;
   logic [TOT_EXT_W-1:0]              cw_tally_ext;
   logic [TOT_EXT_W-1:0]              err_tally_ext;

   // ---------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   // the polynomial alone leaves the frame in progress alone
   assign frame_drop = csr_take &&
                       (csr_index != crc_fc_pkg::CSR_GEN_POLY);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_wide_ff <= crc_fc_pkg::WIDE_RESET;
         cfg_poly_ff <= crc_fc_pkg::POLY_RESET;
         cfg_glen_ff <= crc_fc_pkg::GLEN_RESET;
         cfg_pad_ff  <= crc_fc_pkg::PAD_RESET;
      end else if (csr_take) begin
         case (crc_fc_pkg::csr_reg_type'(csr_index))
            crc_fc_pkg::CSR_WIDE_MODE: begin
               cfg_wide_ff <= csr_write_data[0];
            end
            crc_fc_pkg::CSR_GEN_POLY: begin
               cfg_poly_ff <= csr_write_data;
            end
            crc_fc_pkg::CSR_GEN_LEN: begin
               cfg_glen_ff <= csr_write_data[crc_fc_pkg::GLEN_W-1:0];
            end
            crc_fc_pkg::CSR_PAD_BITS: begin
               cfg_pad_ff <= csr_write_data[crc_fc_pkg::PAD_W-1:0];
            end
            default: begin
               cfg_wide_ff <= cfg_wide_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // frame geometry from the registers
   // ---------------------------------------------------------------
   // generator length clamped into the supported range
   always_comb begin
      if (int'(cfg_glen_ff) < crc_fc_pkg::MIN_GEN_LEN) begin
         gen_len = GL_W'(crc_fc_pkg::MIN_GEN_LEN);
      end else if (int'(cfg_glen_ff) > MAX_GEN_LEN) begin
         gen_len = GL_W'(MAX_GEN_LEN);
      end else begin
         gen_len = GL_W'(cfg_glen_ff);
      end
   end

   // wide: one codeword of 7+g bits; narrow: two of 3+g bits
   always_comb begin
      if (cfg_wide_ff) begin
         frame_bits = FB_W'(cfg_pad_ff) + FB_W'(gen_len) + FB_W'(DATA_W - 1);
         cw_len     = LEN_W'(gen_len) + LEN_W'(DATA_W - 1);
      end else begin
         frame_bits = FB_W'(cfg_pad_ff) + FB_W'(2 * (NIBBLE_W - 1)) +
                      (FB_W'(gen_len) << 1);
         cw_len     = LEN_W'(gen_len) + LEN_W'(NIBBLE_W - 1);
      end
   end

   // whole bytes only, a short tail reads as zeros
   assign frame_bytes = CNT_W'(frame_bits >> 3);

   // ---------------------------------------------------------------
   // byte gather and frame register
   // ---------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hold_move = hold_vld_ff && out_free;
   assign req_stall = hold_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign shifted    = {frame_ff[FRAME_W-BYTE_W-1:0], req_in_byte};
   assign count_inc  = count_ff + 1'b1;
   assign frame_done = (count_inc == frame_bytes);
   // stale bytes above the frame fall off the top here
   assign byte_gap   = CNT_W'(MAX_BYTES) - frame_bytes;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         count_ff <= '0;
      end else if (frame_drop) begin
         frame_ff <= '0;
         count_ff <= '0;
      end else if (req_take) begin
         if (frame_done) begin
            frame_ff <= '0;
            count_ff <= '0;
         end else begin
            frame_ff <= shifted;
            count_ff <= count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else if (req_take && frame_done) begin
         hold_vld_ff <= 1'b1;
      end else if (hold_move) begin
         hold_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && frame_done) begin
         hold_frame_ff <= shifted << {byte_gap, 3'b000};
      end
   end

   // ---------------------------------------------------------------
   // codeword extraction and remainder check
   // ---------------------------------------------------------------
   assign frame_ext = {hold_frame_ff, {CW_W{1'b0}}};
   assign sh_hi     = SH_W'(EXT_W) - SH_W'(cfg_pad_ff) - SH_W'(cw_len);
   assign sh_lo     = sh_hi - SH_W'(cw_len);
   assign cw_hi_raw = frame_ext >> sh_hi;
   assign cw_lo_raw = frame_ext >> sh_lo;

   assign len_mask_full = ({{CW_W{1'b0}}, 1'b1} << cw_len) - 1'b1;
   assign len_mask      = len_mask_full[CW_W-1:0];
   assign cw_hi         = cw_hi_raw[CW_W-1:0] & len_mask;
   assign cw_lo         = cw_lo_raw[CW_W-1:0] & len_mask;

   // generator bits above the length are ignored
   assign poly_ext = POLY_EXT_W'(cfg_poly_ff);
   assign gen_mask = ({{MAX_GEN_LEN{1'b0}}, 1'b1} << gen_len) - 1'b1;
   assign gen_div  = poly_ext[MAX_GEN_LEN-1:0] & gen_mask[MAX_GEN_LEN-1:0];

   crc_fc_divide #(
      .MAX_GEN_LEN (MAX_GEN_LEN)
   ) u_div_hi (
      .cw_word      (cw_hi),
      .cw_len       (cw_len),
      .gen_len      (gen_len),
      .gen_div      (gen_div),
      .remainder_nz (err_hi)
   );

   crc_fc_divide #(
      .MAX_GEN_LEN (MAX_GEN_LEN)
   ) u_div_lo (
      .cw_word      (cw_lo),
      .cw_len       (cw_len),
      .gen_len      (gen_len),
      .gen_div      (gen_div),
      .remainder_nz (err_lo)
   );

   // dataword sits above the g-1 check bits
   assign data_hi = cw_hi >> (gen_len - 1'b1);
   assign data_lo = cw_lo >> (gen_len - 1'b1);

   always_comb begin
      if (cfg_wide_ff) begin
         data_in = data_hi[DATA_W-1:0];
         errs_in = {1'b0, err_hi};
         ncw     = 2'd1;
      end else begin
         data_in = {data_hi[NIBBLE_W-1:0], data_lo[NIBBLE_W-1:0]};
         errs_in = {1'b0, err_hi} + {1'b0, err_lo};
         ncw     = 2'd2;
      end
   end

   // ---------------------------------------------------------------
   // result register and running tallies
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (hold_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_move) begin
         rsp_data_ff <= data_in;
         rsp_errs_ff <= errs_in;
      end
   end

   // tallies move only with a new result, so they hold while it is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_tally_ff  <= '0;
         err_tally_ff <= '0;
      end else if (hold_move) begin
         cw_tally_ff  <= cw_tally_ff + COUNT_WIDTH'(ncw);
         err_tally_ff <= err_tally_ff + COUNT_WIDTH'(errs_in);
      end
   end

   assign cw_tally_ext  = TOT_EXT_W'(cw_tally_ff);
   assign err_tally_ext = TOT_EXT_W'(err_tally_ff);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data_byte       = rsp_data_ff;
   assign rsp_frame_errors    = rsp_errs_ff;
   assign rsp_total_codewords = cw_tally_ext[crc_fc_pkg::TOTAL_W-1:0];
   assign rsp_total_errors    = err_tally_ext[crc_fc_pkg::TOTAL_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/crc_fc_divide.sv
`default_nettype none

module crc_fc_divide #(
   parameter int MAX_GEN_LEN = 9
) (
   input  wire logic [crc_fc_pkg::DATA_W-1+MAX_GEN_LEN-1:0]           cw_word,
   input  wire logic [$clog2(crc_fc_pkg::DATA_W+MAX_GEN_LEN)-1:0]     cw_len,
   input  wire logic [$clog2(MAX_GEN_LEN+1)-1:0]                      gen_len,
   input  wire logic [MAX_GEN_LEN-1:0]                                gen_div,
   output logic                                                       remainder_nz
);

   localparam int CW_W  = crc_fc_pkg::DATA_W - 1 + MAX_GEN_LEN;
   localparam int LEN_W = $clog2(CW_W + 1);
   localparam int IW    = $clog2(CW_W);
   localparam int STEPS = crc_fc_pkg::DATA_W;

   // long division, one generator alignment per step, msb first
   always_comb begin
      logic [CW_W-1:0]        rem;
      logic [IW-1:0]          top;
      logic [LEN_W-1:0]       shamt;
      logic [MAX_GEN_LEN-1:0] rmask;
      rem   = cw_word;
      top   = '0;
      shamt = '0;
      for (int i = 0; i < STEPS; i++) begin
         if (int'(gen_len) + i <= int'(cw_len)) begin
            top   = IW'(int'(cw_len) - 1 - i);
            shamt = LEN_W'(int'(cw_len) - int'(gen_len) - i);
            if (rem[top]) begin
               rem = rem ^ (CW_W'(gen_div) << shamt);
            end
         end
      end
      // remainder is the low gen_len-1 bits
      rmask = ({{(MAX_GEN_LEN-1){1'b0}}, 1'b1} << (gen_len - 1'b1)) - 1'b1;
      remainder_nz = |(rem[MAX_GEN_LEN-1:0] & rmask);
   end

endmodule

`default_nettype wire

FILE: rtl/core/crc_fc_check.sv
`default_nettype none

`include "crc_frame_checker_defines.svh"

module crc_fc_check #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic [crc_fc_pkg::DATA_W-1:0]     rsp_data_byte,
   input  wire logic [crc_fc_pkg::ERR_W-1:0]      rsp_frame_errors,
   input  wire logic [crc_fc_pkg::TOTAL_W-1:0]    rsp_total_codewords,
   input  wire logic [crc_fc_pkg::TOTAL_W-1:0]    rsp_total_errors
);

   // visible part of a tally that wraps at COUNT_WIDTH bits
   localparam logic [crc_fc_pkg::TOTAL_W-1:0] TOTAL_MASK =
      (COUNT_WIDTH >= crc_fc_pkg::TOTAL_W) ? {crc_fc_pkg::TOTAL_W{1'b1}} :
      crc_fc_pkg::TOTAL_W'((64'd1 << COUNT_WIDTH) - 64'd1);

   // stalled result holds, totals included
   `CFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data_byte) && $stable(rsp_frame_errors) && $stable(rsp_total_codewords) && $stable(rsp_total_errors), "stalled result changed")

   // at most two codewords per frame
   `CFC_ASSERT_NOW(a_err_range, clock, reset, rsp_valid, rsp_frame_errors != 2'd3, "frame error count out of range")

   // the error total moves only together with a new frame
   `CFC_ASSERT_NOW(a_err_with_frame, clock, reset, !$past(reset) && !$stable(rsp_total_errors), rsp_valid && !$stable(rsp_total_codewords), "error total moved without a frame")

   // each new frame adds its own error count to the total
   `CFC_ASSERT_NOW(a_err_sum, clock, reset, !$past(reset) && !$stable(rsp_total_codewords), rsp_valid && (rsp_total_errors == (($past(rsp_total_errors) + crc_fc_pkg::TOTAL_W'(rsp_frame_errors)) & TOTAL_MASK)), "error total does not match frame errors")

endmodule

bind crc_frame_checker crc_fc_check #(
   .COUNT_WIDTH (COUNT_WIDTH)
) u_check (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_data_byte       (rsp_data_byte),
   .rsp_frame_errors    (rsp_frame_errors),
   .rsp_total_codewords (rsp_total_codewords),
   .rsp_total_errors    (rsp_total_errors)
);

`default_nettype wire

FILE: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BYTE_W      = crc_fc_pkg::BYTE_W;
   localparam int DATA_W      = crc_fc_pkg::DATA_W;
   localparam int ERR_W       = crc_fc_pkg::ERR_W;
   localparam int TOTAL_W     = crc_fc_pkg::TOTAL_W;
   localparam int POLY_W      = crc_fc_pkg::POLY_W;
   localparam int GLEN_W      = crc_fc_pkg::GLEN_W;
   localparam int PAD_W       = crc_fc_pkg::PAD_W;
   localparam int CSR_DATA_W  = crc_fc_pkg::CSR_DATA_W;
   localparam int MIN_GEN_LEN = crc_fc_pkg::MIN_GEN_LEN;

   // one expected frame result, fields at the port widths
   typedef struct packed {
      logic [DATA_W-1:0]  data_byte;
      logic [ERR_W-1:0]   frame_errors;
      logic [TOTAL_W-1:0] total_codewords;
      logic [TOTAL_W-1:0] total_errors;
   } frame_result_type;

   localparam int MAX_GEN = 9;

   // clock, reset and the block's inputs, known from time zero
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [BYTE_W-1:0]       req_in_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [DATA_W-1:0]       rsp_data_byte;
   logic [ERR_W-1:0]        rsp_frame_errors;
   logic [TOTAL_W-1:0]      rsp_total_codewords;
   logic [TOTAL_W-1:0]      rsp_total_errors;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   crc_fc_pkg::csr_reg_type csr_index = crc_fc_pkg::CSR_WIDE_MODE;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   // shadow copy of the register file, reset values from the package
   logic                    cfg_wide = crc_fc_pkg::WIDE_RESET;
   logic [POLY_W-1:0]       cfg_poly = crc_fc_pkg::POLY_RESET;
   logic [GLEN_W-1:0]       cfg_glen = crc_fc_pkg::GLEN_RESET;
   logic [PAD_W-1:0]        cfg_pad  = crc_fc_pkg::PAD_RESET;

   // shadow frame gather state and running tallies
   logic [23:0]             frame_bits = '0;
   int                      bytes_held = 0;
   logic [TOTAL_W-1:0]      codeword_total = '0;
   logic [TOTAL_W-1:0]      error_total = '0;

   // results still owed by the block, oldest first
   frame_result_type        expected_frames[$];

   // idling odds in percent per cycle
   int                      send_gap_pct = 38;
   int                      recv_stall_pct = 83;

   // run statistics
   int                      bytes_sent = 0;
   int                      frames_checked = 0;
   int                      frames_flagged = 0;
   int                      csr_writes = 0;
   int                      mismatch_count = 0;

   crc_frame_checker DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_in_byte         (req_in_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_frame_errors    (rsp_frame_errors),
      .rsp_total_codewords (rsp_total_codewords),
      .rsp_total_errors    (rsp_total_errors),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // generator length as the datapath uses it, out of range values clamp
   function automatic int active_gen_len();
      if (cfg_glen < MIN_GEN_LEN) return MIN_GEN_LEN;
      if (cfg_glen > MAX_GEN) return MAX_GEN;
      return int'(cfg_glen);
   endfunction

   // whole bytes per frame for the current settings
   function automatic int frame_len();
      int g;
      int nbits;
      g = active_gen_len();
      nbits = cfg_wide ? (int'(cfg_pad) + g - 1 + 8) : (int'(cfg_pad) + 2 * (3 + g));
      return nbits / 8;
   endfunction

   // mod-2 long division, plain xor step at every set leading bit;
   // returns only the low g-1 bits, i.e. the remainder
   function automatic logic [15:0] crc_remainder(input logic [15:0] cw, input int len);
      int g;
      logic [15:0] divisor;
      g = active_gen_len();
      divisor = 16'(cfg_poly) & ((16'd1 << g) - 16'd1);
      for (int i = 0; i + g <= len; i++) begin
         if (cw[len-1-i]) cw = cw ^ (divisor << (len - g - i));
      end
      return cw & ((16'd1 << (g - 1)) - 16'd1);
   endfunction

   // pull len frame bits starting at bit start, first sent bit first;
   // bits past the gathered bytes read as zero
   function automatic logic [15:0] take_codeword(input int start, input int len,
                                                 input int nbytes);
      logic [15:0] cw;
      int total;
      cw = '0;
      total = nbytes * 8;
      for (int k = 0; k < len; k++) begin
         cw = cw << 1;
         if (start + k < total) cw[0] = frame_bits[total-1-start-k];
      end
      return cw;
   endfunction

   // fold one accepted byte into the shadow state, queue a result when
   // it closes a frame
   function automatic void gather_byte(input logic [BYTE_W-1:0] b);
      int nb;
      int g;
      int p;
      int len;
      int errs;
      logic [15:0] c1;
      logic [15:0] c2;
      frame_result_type r;
      nb = frame_len();
      g = active_gen_len();
      p = int'(cfg_pad);
      frame_bits = {frame_bits[15:0], b};
      bytes_held++;
      if (bytes_held < nb) return;
      if (cfg_wide) begin
         len = 7 + g;
         c1 = take_codeword(p, len, nb);
         errs = int'(crc_remainder(c1, len) != 0);
         r.data_byte = 8'(c1 >> (len - 8));
         codeword_total = codeword_total + 1;
      end else begin
         len = 3 + g;
         c1 = take_codeword(p, len, nb);
         c2 = take_codeword(p + len, len, nb);
         errs = int'(crc_remainder(c1, len) != 0) + int'(crc_remainder(c2, len) != 0);
         r.data_byte = {4'(c1 >> (len - 4)), 4'(c2 >> (len - 4))};
         codeword_total = codeword_total + 2;
      end
      error_total = error_total + TOTAL_W'(errs);
      r.frame_errors = ERR_W'(errs);
      r.total_codewords = codeword_total;
      r.total_errors = error_total;
      expected_frames.push_back(r);
      if (errs != 0) frames_flagged++;
      frame_bits = '0;
      bytes_held = 0;
   endfunction

   // one byte on the req_ channel; valid stays up after acceptance so a
   // following item goes out back to back
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         req_in_byte <= BYTE_W'($urandom);
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      gather_byte(b);
      bytes_sent++;
   endtask

   // well-formed frame with random datawords and pad bits; corrupt flips
   // one bit in some codewords
   task automatic send_frame(input bit corrupt);
      logic [63:0] bits;
      logic [15:0] cw;
      logic [7:0] dw;
      int nbits;
      int g;
      int len;
      int ncw;
      int nb;
      g = active_gen_len();
      nb = frame_len();
      len = cfg_wide ? 7 + g : 3 + g;
      ncw = cfg_wide ? 1 : 2;
      nbits = int'(cfg_pad);
      bits = 64'($urandom) & ((64'd1 << cfg_pad) - 64'd1);
      for (int c = 0; c < ncw; c++) begin
         dw = 8'($urandom);
         if (!cfg_wide) dw[7:4] = 4'd0;
         cw = 16'(dw) << (g - 1);
         cw = cw | crc_remainder(cw, len);
         if (corrupt && $urandom_range(2) != 0) cw[$urandom_range(len - 1)] ^= 1'b1;
         bits = (bits << len) | 64'(cw);
         nbits += len;
      end
      // frame is floor(bits / 8) bytes, the tail past it is never sent
      bits = bits >> (nbits - nb * 8);
      for (int k = nb - 1; k >= 0; k--) send_byte(bits[k*8 +: 8]);
   endtask

   // drop valid, wait for every owed result, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write; valid stays up when more writes follow
   task automatic csr_write(input crc_fc_pkg::csr_reg_type idx,
                            input logic [CSR_DATA_W-1:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         crc_fc_pkg::CSR_WIDE_MODE: cfg_wide = data[0];
         crc_fc_pkg::CSR_GEN_POLY:  cfg_poly = data[POLY_W-1:0];
         crc_fc_pkg::CSR_GEN_LEN:   cfg_glen = data[GLEN_W-1:0];
         crc_fc_pkg::CSR_PAD_BITS:  cfg_pad  = data[PAD_W-1:0];
         default:                   cfg_wide = cfg_wide;
      endcase
      // anything but a polynomial write drops the partial frame
      if (idx != crc_fc_pkg::CSR_GEN_POLY) begin
         frame_bits = '0;
         bytes_held = 0;
      end
      csr_writes++;
      if (last) csr_valid <= 1'b0;
   endtask

   // full register set once the block is idle; junk in the unused data bits
   task automatic set_config(input logic wide, input logic [POLY_W-1:0] poly,
                             input logic [GLEN_W-1:0] glen, input logic [PAD_W-1:0] pad);
      wait_idle();
      csr_write(crc_fc_pkg::CSR_WIDE_MODE, {8'($urandom), wide}, 1'b0);
      csr_write(crc_fc_pkg::CSR_GEN_POLY, poly, 1'b0);
      csr_write(crc_fc_pkg::CSR_GEN_LEN, {5'($urandom), glen}, 1'b0);
      csr_write(crc_fc_pkg::CSR_PAD_BITS, {6'($urandom), pad}, 1'b1);
   endtask

   // reset defaults: wide mode, 4-bit generator, one pad bit, one byte
   // frames whose codeword tail reads as zero
   task automatic test_reset_defaults();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(1'b0);
   endtask

   // two datawords per frame at the largest and smallest frame sizes
   task automatic test_narrow_extremes();
      set_config(1'b0, 9'h13B, 4'd9, 3'd7);
      send_frame(1'b0);
      send_frame(1'b1);
      set_config(1'b0, 9'h003, 4'd2, 3'd0);
      send_byte(8'hFF);
      send_byte(8'h00);
   endtask

   // one 8-bit dataword per frame at both generator extremes
   task automatic test_wide_extremes();
      set_config(1'b1, 9'h1FF, 4'd9, 3'd7);
      send_frame(1'b0);
      set_config(1'b1, 9'h003, 4'd2, 3'd0);
      send_byte(8'hFF);
   endtask

   // generator lengths below and above the legal range clamp
   task automatic test_gen_len_clamp();
      set_config(1'b1, 9'h1FF, 4'd0, 3'd0);
      send_frame(1'b0);
      set_config(1'b1, 9'h1FF, 4'd15, 3'd0);
      send_frame(1'b1);
   endtask

   // generator whose leading bit is zero, and polynomial bits above the length
   task automatic test_odd_generators();
      set_config(1'b1, 9'h005, 4'd5, 3'd3);
      send_frame(1'b0);
      set_config(1'b0, 9'h1F3, 4'd4, 3'd0);
      send_frame(1'b1);
   endtask

   // polynomial write keeps a partial frame, other writes drop it
   task automatic test_midframe_writes();
      set_config(1'b0, 9'h1A5, 4'd9, 3'd7);
      send_byte(8'($urandom));
      wait_idle();
      csr_write(crc_fc_pkg::CSR_GEN_POLY, 9'h1D5, 1'b1);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      wait_idle();
      csr_write(crc_fc_pkg::CSR_PAD_BITS, {6'($urandom), 3'd7}, 1'b1);
      send_frame(1'b0);
   endtask

   // random settings, mostly well-formed frames, some corrupted, some noise,
   // and now and then a partial frame cut off by the next setting
   task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                      input int n_bytes);
      int stop_at;
      int seg_end;
      int g;
      logic [GLEN_W-1:0] glen;
      logic [POLY_W-1:0] poly;
      send_gap_pct = gap_pct;
      recv_stall_pct = stall_pct;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         case ($urandom_range(3))
            0: glen = $urandom_range(1) ? 4'd2 : 4'd9;
            1: glen = GLEN_W'($urandom_range(15));
            default: glen = GLEN_W'($urandom_range(9, 2));
         endcase
         g = glen < MIN_GEN_LEN ? MIN_GEN_LEN : (glen > MAX_GEN ? MAX_GEN : int'(glen));
         poly = POLY_W'($urandom_range(511));
         // usually a proper generator with its leading bit set
         if ($urandom_range(3) != 0) poly[g-1] = 1'b1;
         set_config(1'($urandom_range(1)), poly, glen, PAD_W'($urandom_range(7)));
         seg_end = bytes_sent + $urandom_range(60, 15);
         while (bytes_sent < seg_end) begin
            if ($urandom_range(9) != 0) send_frame($urandom_range(2) == 0);
            else repeat (frame_len()) send_byte(8'($urandom));
         end
         if ($urandom_range(3) == 0) repeat ($urandom_range(frame_len() - 1))
            send_byte(8'($urandom));
      end
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic check_field(input string field, input logic [TOTAL_W-1:0] want,
                              input logic [TOTAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // every accepted result against the oldest expectation
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_frames.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual data_byte %0h",
                     $time, rsp_data_byte);
            mismatch_count++;
         end else begin
            want = expected_frames.pop_front();
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("frame_errors", want.frame_errors, rsp_frame_errors);
            check_field("total_codewords", want.total_codewords, rsp_total_codewords);
            check_field("total_errors", want.total_errors, rsp_total_errors);
            frames_checked++;
         end
      end
   end

   // sequence of tests
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_narrow_extremes();
      test_wide_extremes();
      test_gen_len_clamp();
      test_odd_generators();
      test_midframe_writes();
      // fast sender with a mostly stalled receiver, then the reverse, then flat out
      test_random_traffic(38, 83, 330);
      test_random_traffic(83, 38, 330);
      test_random_traffic(0, 0, 330);
      wait_idle();
      repeat (10) @(posedge clock);
      $display("covered %0d bytes in %0d checked frames, %0d of them with bad codewords,",
               bytes_sent, frames_checked, frames_flagged);
      $display("across %0d register writes in both modes and all generator lengths",
               csr_writes);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: crc_frame_checker.f
+incdir+rtl/core
rtl/core/crc_fc_pkg.sv
rtl/core/crc_fc_divide.sv
rtl/core/crc_frame_checker.sv
rtl/core/crc_fc_check.sv
tb/sv/tb.sv
